/* design/esc_pkg.sv */
// Shared types, register codes and saturation helper for the escape-time iteration counter.
package esc_pkg;

    localparam int COORD_W = 64;
    localparam int STEP_W  = 63;
    localparam int LIMIT_W = 16;
    localparam int INDEX_W = 9;
    localparam int WIDE_W  = 128;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ORIGIN_REAL     = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_IMAG     = 3'd1;
    localparam t_cfg_idx CFG_PIXEL_STEP      = 3'd2;
    localparam t_cfg_idx CFG_ITERATION_LIMIT = 3'd3;
    localparam t_cfg_idx CFG_ESCAPE_LIMIT    = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_real;
        logic signed [COORD_W-1:0] origin_imag;
        logic        [STEP_W-1:0]  pixel_step;
        logic        [LIMIT_W-1:0] iteration_limit;
        logic        [STEP_W-1:0]  escape_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
        logic        [INDEX_W-1:0] column;
        logic        [INDEX_W-1:0] row;
    } t_job;

    // Clamp a 128-bit two's complement value to the signed 64-bit range.
    function automatic logic signed [COORD_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[WIDE_W-1]}}) begin
            r = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* design/esc_front.sv */
// Front end: accepts pixel requests and forms the complex coordinate c for each one.
module esc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esc_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [esc_pkg::INDEX_W-1:0]  i_column,
    input  logic [esc_pkg::INDEX_W-1:0]  i_row,
    output logic                         o_push,
    input  logic                         i_push_ready,
    output esc_pkg::t_job                o_job
);

    localparam int PROD_W = esc_pkg::INDEX_W + esc_pkg::STEP_W;

    logic                        r_vld;
    logic [esc_pkg::INDEX_W-1:0] r_col;
    logic [esc_pkg::INDEX_W-1:0] r_row;
    logic [PROD_W-1:0]           r_pre;
    logic [PROD_W-1:0]           r_pim;
    logic [PROD_W-1:0]           n_pre;
    logic [PROD_W-1:0]           n_pim;
    logic signed [esc_pkg::WIDE_W-1:0] w_sum_re;
    logic signed [esc_pkg::WIDE_W-1:0] w_sum_im;

    assign o_ready = !r_vld || i_push_ready;
    assign o_push  = r_vld;

    assign n_pre = PROD_W'(i_column) * PROD_W'(i_cfg.pixel_step);
    assign n_pim = PROD_W'(i_row) * PROD_W'(i_cfg.pixel_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_col <= i_column;
            r_row <= i_row;
            r_pre <= n_pre;
            r_pim <= n_pim;
        end
    end

    // The index product is never negative; the origin is sign-extended.
    assign w_sum_re = {{(esc_pkg::WIDE_W-esc_pkg::COORD_W){i_cfg.origin_real[esc_pkg::COORD_W-1]}},
                       i_cfg.origin_real}
                    + {{(esc_pkg::WIDE_W-PROD_W){1'b0}}, r_pre};
    assign w_sum_im = {{(esc_pkg::WIDE_W-esc_pkg::COORD_W){i_cfg.origin_imag[esc_pkg::COORD_W-1]}},
                       i_cfg.origin_imag}
                    + {{(esc_pkg::WIDE_W-PROD_W){1'b0}}, r_pim};

    assign o_job.c_re   = esc_pkg::sat64(w_sum_re);
    assign o_job.c_im   = esc_pkg::sat64(w_sum_im);
    assign o_job.column = r_col;
    assign o_job.row    = r_row;

endmodule

/* design/esc_fifo.sv */
// Short request queue between the front end and the iteration engine.
module esc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  esc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_pop,
    output esc_pkg::t_job o_job
);

    esc_pkg::t_job                r_mem [esc_pkg::QUEUE_DEPTH];
    logic [esc_pkg::QPTR_W-1:0]   r_wp;
    logic [esc_pkg::QPTR_W-1:0]   r_rp;
    logic [esc_pkg::QCNT_W-1:0]   r_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_ready = (r_cnt != esc_pkg::QCNT_W'(esc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + esc_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + esc_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + esc_pkg::QCNT_W'(w_push) - esc_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* design/esc_mul.sv */
// Serial signed 64 x 64 multiplier built from four 33 x 33 partial products.
module esc_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [esc_pkg::COORD_W-1:0]  i_a,
    input  logic signed [esc_pkg::COORD_W-1:0]  i_b,
    output logic                                o_done,
    output logic signed [esc_pkg::WIDE_W-1:0]   o_prod
);

    localparam int HALF_W = esc_pkg::COORD_W / 2;
    localparam int OP_W   = HALF_W + 1;
    localparam int PP_W   = 2 * OP_W;

    logic signed [esc_pkg::COORD_W-1:0] r_a;
    logic signed [esc_pkg::COORD_W-1:0] r_b;
    logic                               r_issue;
    logic [1:0]                         r_step;
    logic signed [PP_W-1:0]             r_pp;
    logic [1:0]                         r_pp_sh;
    logic                               r_pp_vld;
    logic signed [esc_pkg::WIDE_W-1:0]  r_acc;
    logic                               r_done;

    logic signed [OP_W-1:0]             w_op_a;
    logic signed [OP_W-1:0]             w_op_b;
    logic signed [PP_W-1:0]             w_pp;
    logic signed [esc_pkg::WIDE_W-1:0]  w_pp_ext;
    logic signed [esc_pkg::WIDE_W-1:0]  w_term;

    // Low halves are unsigned, high halves carry the sign of the operand.
    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_op_a = {1'b0, r_a[HALF_W-1:0]};
                w_op_b = {1'b0, r_b[HALF_W-1:0]};
            end
            2'd1: begin
                w_op_a = {1'b0, r_a[HALF_W-1:0]};
                w_op_b = {r_b[esc_pkg::COORD_W-1], r_b[esc_pkg::COORD_W-1:HALF_W]};
            end
            2'd2: begin
                w_op_a = {r_a[esc_pkg::COORD_W-1], r_a[esc_pkg::COORD_W-1:HALF_W]};
                w_op_b = {1'b0, r_b[HALF_W-1:0]};
            end
            default: begin
                w_op_a = {r_a[esc_pkg::COORD_W-1], r_a[esc_pkg::COORD_W-1:HALF_W]};
                w_op_b = {r_b[esc_pkg::COORD_W-1], r_b[esc_pkg::COORD_W-1:HALF_W]};
            end
        endcase
    end

    assign w_pp     = w_op_a * w_op_b;
    assign w_pp_ext = {{(esc_pkg::WIDE_W-PP_W){r_pp[PP_W-1]}}, r_pp};

    always_comb begin
        unique case (r_pp_sh)
            2'd0:    w_term = w_pp_ext;
            2'd1:    w_term = w_pp_ext <<< HALF_W;
            2'd2:    w_term = w_pp_ext <<< HALF_W;
            default: w_term = w_pp_ext <<< esc_pkg::COORD_W;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_step   <= 2'd0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pp_vld <= r_issue;
            r_done   <= r_pp_vld && (r_pp_sh == 2'd3);
            if (i_start) begin
                r_issue <= 1'b1;
                r_step  <= 2'd0;
            end else if (r_issue) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_issue <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + w_term;
        end
        if (r_issue) begin
            r_pp    <= w_pp;
            r_pp_sh <= r_step;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* design/esc_back.sv */
// Iteration engine: runs z = z*z + c on one pixel at a time and holds the result.
module esc_back #(
    parameter int FRACTION_BITS = 60
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esc_pkg::t_cfg                i_cfg,
    input  logic                         i_job_valid,
    output logic                         o_job_pop,
    input  esc_pkg::t_job                i_job,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [esc_pkg::LIMIT_W-1:0]  o_count,
    output logic [esc_pkg::INDEX_W-1:0]  o_column,
    output logic [esc_pkg::INDEX_W-1:0]  o_row
);

    localparam int CW = esc_pkg::COORD_W;
    localparam int WW = esc_pkg::WIDE_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MXY  = 5'b00010,
        S_MXX  = 5'b00100,
        S_MYY  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_start, n_start;
    logic signed [CW-1:0]          r_cre, n_cre;
    logic signed [CW-1:0]          r_cim, n_cim;
    logic [esc_pkg::INDEX_W-1:0]   r_col, n_col;
    logic [esc_pkg::INDEX_W-1:0]   r_row, n_row;
    logic signed [CW-1:0]          r_x, n_x;
    logic signed [CW-1:0]          r_y, n_y;
    logic signed [WW-1:0]          r_xx, n_xx;
    logic signed [WW-1:0]          r_yy, n_yy;
    logic [esc_pkg::LIMIT_W-1:0]   r_count, n_count;
    logic                          r_out_vld, n_out_vld;
    logic [esc_pkg::LIMIT_W-1:0]   r_out_count, n_out_count;
    logic [esc_pkg::INDEX_W-1:0]   r_out_col, n_out_col;
    logic [esc_pkg::INDEX_W-1:0]   r_out_row, n_out_row;

    logic signed [CW-1:0]          w_mul_a;
    logic signed [CW-1:0]          w_mul_b;
    logic                          w_mul_done;
    logic signed [WW-1:0]          w_prod;
    logic signed [WW-1:0]          w_sq;
    logic signed [WW-1:0]          w_xy2;
    logic signed [WW-1:0]          w_re_sum;
    logic signed [WW-1:0]          w_im_sum;
    logic [WW-1:0]                 w_mag;
    logic                          w_escape;

    // Operands are taken from the state the product is issued in.
    assign w_mul_a = (r_state == S_MYY) ? r_y : r_x;
    assign w_mul_b = (r_state == S_MXX) ? r_x : r_y;

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_sq     = w_prod >>> FRACTION_BITS;
    assign w_xy2    = w_prod >>> (FRACTION_BITS - 1);
    assign w_re_sum = r_xx - r_yy + {{(WW-CW){r_cre[CW-1]}}, r_cre};
    assign w_im_sum = w_xy2 + {{(WW-CW){r_cim[CW-1]}}, r_cim};

    // The squared magnitude is never negative, so an unsigned compare is exact.
    assign w_mag    = r_xx + w_sq;
    assign w_escape = (w_mag[WW-1:CW] != '0) || (w_mag[CW-1:0] > {1'b0, i_cfg.escape_limit});

    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_col       = r_col;
        n_row       = r_row;
        n_x         = r_x;
        n_y         = r_y;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_count     = r_count;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_count = r_out_count;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        o_job_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cre     = i_job.c_re;
                    n_cim     = i_job.c_im;
                    n_col     = i_job.column;
                    n_row     = i_job.row;
                    n_x       = '0;
                    n_y       = '0;
                    n_xx      = '0;
                    n_yy      = '0;
                    n_count   = '0;
                    if (i_cfg.iteration_limit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MXY;
                        n_start = 1'b1;
                    end
                end
            end
            S_MXY: begin
                if (w_mul_done) begin
                    n_x     = esc_pkg::sat64(w_re_sum);
                    n_y     = esc_pkg::sat64(w_im_sum);
                    n_count = r_count + esc_pkg::LIMIT_W'(1);
                    n_state = S_MXX;
                    n_start = 1'b1;
                end
            end
            S_MXX: begin
                if (w_mul_done) begin
                    n_xx    = w_sq;
                    n_state = S_MYY;
                    n_start = 1'b1;
                end
            end
            S_MYY: begin
                if (w_mul_done) begin
                    n_yy = w_sq;
                    if (w_escape || (r_count == i_cfg.iteration_limit)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MXY;
                        n_start = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld   = 1'b1;
                    n_out_count = r_count;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cre       <= n_cre;
        r_cim       <= n_cim;
        r_col       <= n_col;
        r_row       <= n_row;
        r_x         <= n_x;
        r_y         <= n_y;
        r_xx        <= n_xx;
        r_yy        <= n_yy;
        r_count     <= n_count;
        r_out_count <= n_out_count;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
    end

    assign o_valid  = r_out_vld;
    assign o_count  = r_out_count;
    assign o_column = r_out_col;
    assign o_row    = r_out_row;

`ifndef SYNTHESIS
    a_start_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_MXY || r_state == S_MXX || r_state == S_MYY))
        else $error("multiplier started outside a multiply state");

    a_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MXY || r_state == S_MXX || r_state == S_MYY))
        else $error("product finished while the engine was not waiting for it");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_count <= i_cfg.iteration_limit))
        else $error("result count exceeds the iteration limit");
`endif

endmodule

/* design/escape_time_iteration_counter.sv */
// Escape-time pixel engine: each iteration runs three 64x64 products in turn on the shared
// serial multiplier; a two-entry queue lets the front end accept new pixels while the
// engine is still iterating on an earlier one.
// Reset is synchronous, active low: it restores the default register values and
// empties the queue, the engine and the output register.
module escape_time_iteration_counter #(
    parameter int FRACTION_BITS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // column[8:0], row[17:9], zero fill
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // iteration_count[15:0], column[24:16], row[33:25]
    input  logic        i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [esc_pkg::COORD_W-1:0]   i_cfg_data
);

    localparam logic [esc_pkg::COORD_W-1:0] ORIGIN_RST =
        esc_pkg::COORD_W'(0) - (esc_pkg::COORD_W'(2) << FRACTION_BITS);
    localparam logic [esc_pkg::STEP_W-1:0] STEP_RST =
        esc_pkg::STEP_W'(1) << (FRACTION_BITS - 7);
    localparam logic [esc_pkg::STEP_W-1:0] ESCAPE_RST =
        esc_pkg::STEP_W'(2) << FRACTION_BITS;

    esc_pkg::t_cfg r_cfg;
    logic          w_push;
    logic          w_push_ready;
    esc_pkg::t_job w_front_job;
    logic          w_job_valid;
    logic          w_job_pop;
    esc_pkg::t_job w_job;
    logic [esc_pkg::LIMIT_W-1:0] w_count;
    logic [esc_pkg::INDEX_W-1:0] w_out_col;
    logic [esc_pkg::INDEX_W-1:0] w_out_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real     <= ORIGIN_RST;
            r_cfg.origin_imag     <= ORIGIN_RST;
            r_cfg.pixel_step      <= STEP_RST;
            r_cfg.iteration_limit <= esc_pkg::LIMIT_RST;
            r_cfg.escape_limit    <= ESCAPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                esc_pkg::CFG_ORIGIN_REAL:     r_cfg.origin_real <= i_cfg_data;
                esc_pkg::CFG_ORIGIN_IMAG:     r_cfg.origin_imag <= i_cfg_data;
                esc_pkg::CFG_PIXEL_STEP:      r_cfg.pixel_step <= i_cfg_data[esc_pkg::STEP_W-1:0];
                esc_pkg::CFG_ITERATION_LIMIT:
                    r_cfg.iteration_limit <= i_cfg_data[esc_pkg::LIMIT_W-1:0];
                esc_pkg::CFG_ESCAPE_LIMIT:
                    r_cfg.escape_limit <= i_cfg_data[esc_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    esc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_column     (i_s_axis_tdata[8:0]),
        .i_row        (i_s_axis_tdata[17:9]),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_job        (w_front_job)
    );

    esc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_push_ready),
        .i_job   (w_front_job),
        .o_valid (w_job_valid),
        .i_pop   (w_job_pop),
        .o_job   (w_job)
    );

    esc_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job       (w_job),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_count     (w_count),
        .o_column    (w_out_col),
        .o_row       (w_out_row)
    );

    assign o_m_axis_tdata = {6'b0, w_out_row, w_out_col, w_count};

endmodule
